// ===== hdl/sfg_pkg.sv =====
// sfg_pkg: widths, latency and sideband types for the spring force gradient pipeline
// no dependencies; used by every module of the block and by its checker
package sfg_pkg;

	localparam int FRAC_BITS_DEF = 16;

	localparam int CW   = 32;            // coordinate and gradient width
	localparam int MW   = 33;            // magnitude of a coordinate difference
	localparam int KW   = 31;            // stiffness and rest length width
	localparam int SQW  = 2 * MW;        // one squared difference
	localparam int SW   = 68;            // sum of squares, with margin
	localparam int LW   = 34;            // square root width
	localparam int EW   = 34;            // magnitude of the stretch
	localparam int KEW  = KW + EW;       // stiffness times stretch
	localparam int PLW  = 33;            // low slice of the stiffness product
	localparam int PHW  = KEW - PLW;     // high slice of the stiffness product
	localparam int NW   = KEW + MW;      // full numerator
	localparam int QW   = 32;            // quotient bits kept
	localparam int DNW  = QW + LW;       // numerator seen by the divider

	// three input stages, root, five middle stages, quotient, output register
	localparam int LATENCY = 3 + LW + 5 + QW + 1;

	typedef struct packed {
		logic [2:0][MW-1:0] mag;
		logic [2:0]         dneg;
		logic [KW-1:0]      rest;
		logic               degen;
	} sfg_sq_side_t;

	typedef struct packed {
		logic neg;
		logic ovf;
		logic degen;
	} sfg_div_side_t;

endpackage

// ===== hdl/sfg_isqrt_pipe.sv =====
// sfg_isqrt_pipe: pipelined integer square root, one result bit per stage
// depends on sfg_pkg
module sfg_isqrt_pipe
	import sfg_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_vld,
	input  logic [SW-1:0] in_sum,
	input  sfg_sq_side_t in_side,
	output logic         out_vld,
	output logic [LW-1:0] out_root,
	output sfg_sq_side_t out_side
);

	logic [SW-1:0]  x_q    [0:LW];
	logic [LW-1:0]  r_q    [0:LW];
	logic           v_q    [0:LW];
	sfg_sq_side_t   side_q [0:LW];

	always_comb begin
		x_q[0]    = in_sum;
		r_q[0]    = '0;
		v_q[0]    = in_vld;
		side_q[0] = in_side;
	end

	for (genvar g = 0; g < LW; g++) begin : g_stage
		localparam int B = LW - 1 - g;
		logic [SW-1:0] trial;
		logic          take;

		// (r + 2^b)^2 - r^2, r holding only bits above b
		always_comb begin
			trial = (SW'(r_q[g]) << (B + 1)) | (SW'(1) << (2 * B));
			take  = x_q[g] >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[g+1] <= 1'b0;
			end else begin
				v_q[g+1] <= v_q[g];
			end
		end

		always_ff @(posedge clk) begin
			x_q[g+1]    <= take ? x_q[g] - trial : x_q[g];
			r_q[g+1]    <= take ? (r_q[g] | (LW'(1) << B)) : r_q[g];
			side_q[g+1] <= side_q[g];
		end
	end

	assign out_vld  = v_q[LW];
	assign out_root = r_q[LW];
	assign out_side = side_q[LW];

endmodule

// ===== hdl/sfg_div_pipe.sv =====
// sfg_div_pipe: pipelined restoring divider, one quotient bit per stage
// depends on sfg_pkg; caller guarantees the upper numerator part is below den
module sfg_div_pipe
	import sfg_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_vld,
	input  logic [DNW-1:0] in_num,
	input  logic [LW-1:0] in_den,
	input  sfg_div_side_t in_side,
	output logic          out_vld,
	output logic [QW-1:0] out_quot,
	output sfg_div_side_t out_side
);

	logic [LW-1:0]  rem_q  [0:QW];
	logic [QW-1:0]  lo_q   [0:QW];
	logic [QW-1:0]  quo_q  [0:QW];
	logic [LW-1:0]  den_q  [0:QW];
	logic           v_q    [0:QW];
	sfg_div_side_t  side_q [0:QW];

	always_comb begin
		rem_q[0]  = in_side.ovf ? '0 : in_num[DNW-1:QW];
		lo_q[0]   = in_num[QW-1:0];
		quo_q[0]  = '0;
		den_q[0]  = in_den;
		v_q[0]    = in_vld;
		side_q[0] = in_side;
	end

	for (genvar g = 0; g < QW; g++) begin : g_stage
		logic [LW:0] trial;
		logic        ge;

		always_comb begin
			trial = {rem_q[g], lo_q[g][QW-1]};
			ge    = trial >= {1'b0, den_q[g]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[g+1] <= 1'b0;
			end else begin
				v_q[g+1] <= v_q[g];
			end
		end

		always_ff @(posedge clk) begin
			rem_q[g+1]  <= ge ? LW'(trial - {1'b0, den_q[g]}) : LW'(trial);
			lo_q[g+1]   <= lo_q[g] << 1;
			quo_q[g+1]  <= {quo_q[g][QW-2:0], ge};
			den_q[g+1]  <= den_q[g];
			side_q[g+1] <= side_q[g];
		end
	end

	assign out_vld  = v_q[QW];
	assign out_quot = quo_q[QW];
	assign out_side = side_q[QW];

endmodule

// ===== hdl/spring_force_gradient.sv =====
// spring_force_gradient: top level of the spring potential gradient pipeline
// depends on sfg_pkg, sfg_isqrt_pipe and sfg_div_pipe
//
// usage
// - a transfer in: start high while busy is low takes pos_a_*, pos_b_* and rest_length
// - busy stays low: the pipeline takes a new spring on every clock
// - a transfer out: done is high for exactly one cycle with grad_a_*, grad_b_* and
//   degenerate; results leave in the order the springs came in
// - results pass in order through differences, squares and sum, the square root,
//   stretch, stiffness products and range check, the divider and an output register
// - throughput is one spring per cycle, set by the fully unrolled root and divider
// - the receiver cannot stall, so results are never held back or dropped
// - stiffness is written by wr_en / wr_data; the user must write it only while no
//   spring is in flight, as the block itself does not enforce this
// - reset clears every valid bit in the pipeline and loads stiffness with 1.0
// - coincident points give zero gradients with degenerate set
// - gradients are rounded toward zero and saturate to the 32-bit range
module spring_force_gradient
	import sfg_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [KW-1:0]        wr_data,
	input  logic                 start,
	output logic                 busy,
	input  logic signed [CW-1:0] pos_a_x,
	input  logic signed [CW-1:0] pos_a_y,
	input  logic signed [CW-1:0] pos_a_z,
	input  logic signed [CW-1:0] pos_b_x,
	input  logic signed [CW-1:0] pos_b_y,
	input  logic signed [CW-1:0] pos_b_z,
	input  logic [KW-1:0]        rest_length,
	output logic                 done,
	output logic signed [CW-1:0] grad_a_x,
	output logic signed [CW-1:0] grad_a_y,
	output logic signed [CW-1:0] grad_a_z,
	output logic signed [CW-1:0] grad_b_x,
	output logic signed [CW-1:0] grad_b_y,
	output logic signed [CW-1:0] grad_b_z,
	output logic                 degenerate
);

	localparam logic [KW-1:0] STIFF_RESET = KW'(64'd1 << FRAC_BITS);
	localparam logic [CW-1:0] SAT_MAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic [CW-1:0] SAT_MIN = {1'b1, {(CW-1){1'b0}}};

	logic [KW-1:0] stiffness_q;

	// stiffness register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stiffness_q <= STIFF_RESET;
		end else if (wr_en) begin
			stiffness_q <= wr_data;
		end
	end

	// never stalls
	assign busy = 1'b0;

	logic take;
	assign take = start && !busy;

	// stage 1: differences as magnitude and sign
	logic signed [CW-1:0] pa [3];
	logic signed [CW-1:0] pb [3];
	logic signed [MW-1:0] diff [3];
	logic                 v_s1;
	logic [2:0][MW-1:0]   mag_s1;
	logic [2:0]           dneg_s1;
	logic [KW-1:0]        rest_s1;

	always_comb begin
		pa[0] = pos_a_x; pa[1] = pos_a_y; pa[2] = pos_a_z;
		pb[0] = pos_b_x; pb[1] = pos_b_y; pb[2] = pos_b_z;
		for (int i = 0; i < 3; i++) begin
			diff[i] = MW'(pa[i]) - MW'(pb[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			mag_s1[i]  <= diff[i][MW-1] ? MW'(-diff[i]) : MW'(diff[i]);
			dneg_s1[i] <= diff[i][MW-1];
		end
		rest_s1 <= rest_length;
	end

	// stage 2: squares
	logic                 v_s2;
	logic [2:0][SQW-1:0]  sq_s2;
	sfg_sq_side_t         side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			sq_s2[i] <= SQW'(mag_s1[i]) * SQW'(mag_s1[i]);
		end
		side_s2.mag   <= mag_s1;
		side_s2.dneg  <= dneg_s1;
		side_s2.rest  <= rest_s1;
		side_s2.degen <= 1'b0;
	end

	// stage 3: squared length, zero means the points coincide
	logic            v_s3;
	logic [SW-1:0]   sum_s3;
	sfg_sq_side_t    side_s3;
	logic [SW-1:0]   sum_c;

	assign sum_c = SW'(sq_s2[0]) + SW'(sq_s2[1]) + SW'(sq_s2[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		sum_s3  <= sum_c;
		side_s3 <= {side_s2.mag, side_s2.dneg, side_s2.rest, sum_c == '0};
	end

	// root of the squared length
	logic           v_rt;
	logic [LW-1:0]  len_rt;
	sfg_sq_side_t   side_rt;

	sfg_isqrt_pipe u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (v_s3),
		.in_sum   (sum_s3),
		.in_side  (side_s3),
		.out_vld  (v_rt),
		.out_root (len_rt),
		.out_side (side_rt)
	);

	// stage 4: stretch magnitude and sign
	logic            v_s4;
	logic [EW-1:0]   eabs_s4;
	logic            eneg_s4;
	logic [LW-1:0]   len_s4;
	sfg_sq_side_t    side_s4;
	logic [EW:0]     ext_c;

	assign ext_c = (EW+1)'(len_rt) - (EW+1)'(side_rt.rest);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_rt;
		end
	end

	always_ff @(posedge clk) begin
		eabs_s4 <= ext_c[EW] ? EW'(-ext_c) : EW'(ext_c);
		eneg_s4 <= ext_c[EW];
		len_s4  <= len_rt;
		side_s4 <= side_rt;
	end

	// stage 5: stiffness times stretch
	logic            v_s5;
	logic [KEW-1:0]  ke_s5;
	logic            eneg_s5;
	logic [LW-1:0]   len_s5;
	sfg_sq_side_t    side_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		ke_s5   <= KEW'(stiffness_q) * KEW'(eabs_s4);
		eneg_s5 <= eneg_s4;
		len_s5  <= len_s4;
		side_s5 <= side_s4;
	end

	// stage 6: numerator partial products, split to keep multipliers narrow
	logic                     v_s6;
	logic [2:0][PLW+MW-1:0]   pl_s6;
	logic [2:0][PHW+MW-1:0]   ph_s6;
	logic [2:0]               neg_s6;
	logic                     degen_s6;
	logic [LW-1:0]            len_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			pl_s6[i]  <= (PLW+MW)'(ke_s5[PLW-1:0]) * (PLW+MW)'(side_s5.mag[i]);
			ph_s6[i]  <= (PHW+MW)'(ke_s5[KEW-1:PLW]) * (PHW+MW)'(side_s5.mag[i]);
			neg_s6[i] <= eneg_s5 ^ side_s5.dneg[i];
		end
		degen_s6 <= side_s5.degen;
		len_s6   <= len_s5;
	end

	// stage 7: full numerator
	logic                v_s7;
	logic [2:0][NW-1:0]  num_s7;
	logic [2:0]          neg_s7;
	logic                degen_s7;
	logic [LW-1:0]       len_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			num_s7[i] <= NW'(pl_s6[i]) + (NW'(ph_s6[i]) << PLW);
		end
		neg_s7   <= neg_s6;
		degen_s7 <= degen_s6;
		len_s7   <= len_s6;
	end

	// stage 8: drop fraction bits, flag quotients beyond 32 bits
	logic                 v_s8;
	logic [2:0][DNW-1:0]  num_s8;
	sfg_div_side_t        side_s8 [3];
	logic [LW-1:0]        len_s8;
	logic [NW-1:0]        nsh [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			nsh[i] = num_s7[i] >> FRAC_BITS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else begin
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			num_s8[i]        <= nsh[i][DNW-1:0];
			side_s8[i].ovf   <= nsh[i][NW-1:QW] >= (NW-QW)'(len_s7);
			side_s8[i].neg   <= neg_s7[i];
			side_s8[i].degen <= degen_s7;
		end
		len_s8 <= len_s7;
	end

	// one divider lane per axis
	logic [2:0]          v_dv;
	logic [QW-1:0]       quo_dv  [3];
	sfg_div_side_t       side_dv [3];

	for (genvar i = 0; i < 3; i++) begin : g_lane
		sfg_div_pipe u_div (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_vld   (v_s8),
			.in_num   (num_s8[i]),
			.in_den   (len_s8),
			.in_side  (side_s8[i]),
			.out_vld  (v_dv[i]),
			.out_quot (quo_dv[i]),
			.out_side (side_dv[i])
		);
	end

	// saturate and sign the quotient, a for the signed value and b for its negation
	logic [CW-1:0] ga_c [3];
	logic [CW-1:0] gb_c [3];

	function automatic logic [CW-1:0] sat_signed(
		input logic [QW-1:0] q,
		input logic          ovf,
		input logic          neg
	);
		logic [CW-1:0] r;
		if (neg) begin
			r = (ovf || q > SAT_MIN) ? SAT_MIN : CW'(-q);
		end else begin
			r = (ovf || q[QW-1]) ? SAT_MAX : CW'(q);
		end
		return r;
	endfunction

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (side_dv[i].degen) begin
				ga_c[i] = '0;
				gb_c[i] = '0;
			end else begin
				ga_c[i] = sat_signed(quo_dv[i], side_dv[i].ovf, side_dv[i].neg);
				gb_c[i] = sat_signed(quo_dv[i], side_dv[i].ovf, !side_dv[i].neg);
			end
		end
	end

	// output register
	logic          done_q;
	logic [CW-1:0] ga_q [3];
	logic [CW-1:0] gb_q [3];
	logic          degen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= v_dv[0];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			ga_q[i] <= ga_c[i];
			gb_q[i] <= gb_c[i];
		end
		degen_q <= side_dv[0].degen;
	end

	assign done       = done_q;
	assign grad_a_x   = ga_q[0];
	assign grad_a_y   = ga_q[1];
	assign grad_a_z   = ga_q[2];
	assign grad_b_x   = gb_q[0];
	assign grad_b_y   = gb_q[1];
	assign grad_b_z   = gb_q[2];
	assign degenerate = degen_q;

endmodule

// ===== hdl/sfg_checker.sv =====
// sfg_checker: port-level assertions for spring_force_gradient, bound to the top level
// depends on sfg_pkg
module sfg_checker
	import sfg_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 start,
	input logic                 busy,
	input logic signed [CW-1:0] pos_a_x,
	input logic signed [CW-1:0] pos_a_y,
	input logic signed [CW-1:0] pos_a_z,
	input logic signed [CW-1:0] pos_b_x,
	input logic signed [CW-1:0] pos_b_y,
	input logic signed [CW-1:0] pos_b_z,
	input logic                 done,
	input logic signed [CW-1:0] grad_a_x,
	input logic signed [CW-1:0] grad_a_y,
	input logic signed [CW-1:0] grad_a_z,
	input logic signed [CW-1:0] grad_b_x,
	input logic signed [CW-1:0] grad_b_y,
	input logic signed [CW-1:0] grad_b_z,
	input logic                 degenerate
);

	localparam logic [CW-1:0] SAT_MAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic [CW-1:0] SAT_MIN = {1'b1, {(CW-1){1'b0}}};
	localparam int AGW = $clog2(LATENCY + 1);

	logic [AGW-1:0] age_q;
	logic           warm;
	logic           same;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			age_q <= '0;
		end else if (age_q != AGW'(LATENCY)) begin
			age_q <= age_q + 1'b1;
		end
	end

	assign warm = age_q == AGW'(LATENCY);
	assign same = pos_a_x == pos_b_x && pos_a_y == pos_b_y && pos_a_z == pos_b_z;

	// each transfer in gives exactly one result a fixed latency later
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		warm |-> done == $past(start && !busy, LATENCY))
		else $error("result strobe does not match transfer in");

	// coincident points come back flagged
	a_degen_in: assert property (@(posedge clk) disable iff (!arst_n)
		warm && $past(start && !busy && same, LATENCY) |-> degenerate)
		else $error("coincident points not flagged");

	// flagged results carry zero gradients
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && degenerate |-> grad_a_x == 0 && grad_a_y == 0 && grad_a_z == 0 &&
			grad_b_x == 0 && grad_b_y == 0 && grad_b_z == 0)
		else $error("degenerate result with nonzero gradient");

	// away from the bounds the b x gradient is the negated a x gradient
	a_negate: assert property (@(posedge clk) disable iff (!arst_n)
		done && grad_a_x != SAT_MAX && grad_a_x != SAT_MIN |-> grad_b_x == -grad_a_x)
		else $error("second gradient is not the negated first");

endmodule

bind spring_force_gradient sfg_checker u_sfg_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.pos_a_x    (pos_a_x),
	.pos_a_y    (pos_a_y),
	.pos_a_z    (pos_a_z),
	.pos_b_x    (pos_b_x),
	.pos_b_y    (pos_b_y),
	.pos_b_z    (pos_b_z),
	.done       (done),
	.grad_a_x   (grad_a_x),
	.grad_a_y   (grad_a_y),
	.grad_a_z   (grad_a_z),
	.grad_b_x   (grad_b_x),
	.grad_b_y   (grad_b_y),
	.grad_b_z   (grad_b_z),
	.degenerate (degenerate)
);

// ===== verif/tb_spring_force_gradient.sv =====
// tb_spring_force_gradient: self-checking bench for the spring potential gradient pipeline
// depends on sfg_pkg and spring_force_gradient; a directed table, then random springs
// under several stiffness settings, each result compared with a table entry or an internal predictor
module tb_spring_force_gradient;
	import sfg_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic signed [CW-1:0] GMAX = 32'sh7fffffff;
	localparam logic signed [CW-1:0] GMIN = 32'sh80000000;
	localparam int STALL_LIMIT = 4000;  // cycles with no transfer before giving up
	localparam int PER_PHASE   = 240;

	// one spring: particle a, particle b, rest length
	typedef struct {
		logic signed [CW-1:0] a[3];
		logic signed [CW-1:0] b[3];
		logic [KW-1:0]        rest;
	} spring_t;

	// gradients a x/y/z then b x/y/z, plus the coincident flag
	typedef struct {
		logic signed [CW-1:0] grad[6];
		logic                 degen;
	} spring_grad_t;

	typedef struct {
		spring_t      s;
		bit           typed;
		spring_grad_t want;
	} stim_row_t;

	logic clk, arst_n;
	logic wr_en;
	logic [KW-1:0] wr_data;
	logic start, busy, done, degenerate;
	logic signed [CW-1:0] pos_a_x, pos_a_y, pos_a_z, pos_b_x, pos_b_y, pos_b_z;
	logic [KW-1:0] rest_length;
	logic signed [CW-1:0] grad_a_x, grad_a_y, grad_a_z, grad_b_x, grad_b_y, grad_b_z;

	spring_grad_t grad_fifo[$];  // gradients still owed by the pipeline, oldest first
	stim_row_t    rows[$];
	logic [KW-1:0] stiffness_model;
	int errors;
	int quiet_cycles;
	int sent;

	spring_force_gradient i_dut (
		.clk(clk), .arst_n(arst_n),
		.wr_en(wr_en), .wr_data(wr_data),
		.start(start), .busy(busy),
		.pos_a_x(pos_a_x), .pos_a_y(pos_a_y), .pos_a_z(pos_a_z),
		.pos_b_x(pos_b_x), .pos_b_y(pos_b_y), .pos_b_z(pos_b_z),
		.rest_length(rest_length),
		.done(done),
		.grad_a_x(grad_a_x), .grad_a_y(grad_a_y), .grad_a_z(grad_a_z),
		.grad_b_x(grad_b_x), .grad_b_y(grad_b_y), .grad_b_z(grad_b_z),
		.degenerate(degenerate)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// clamp an exact gradient to the 32-bit output range
	function automatic logic signed [CW-1:0] clamp32(longint v);
		if (v > longint'(GMAX)) return GMAX;
		if (v < longint'(GMIN)) return GMIN;
		return v[CW-1:0];
	endfunction

	// exact fixed-point gradient: integer root of the squared length, stretch,
	// truncated quotient clipped at 2^62, then saturation per side
	function automatic spring_grad_t spring_gradient(spring_t s, logic [KW-1:0] k);
		longint d[3];
		logic [MW-1:0] m[3];
		logic [67:0] sq;
		logic [LW-1:0] root, cand;
		longint e, v;
		logic [127:0] ke, den, q;
		spring_grad_t r;
		for (int i = 0; i < 3; i++) begin
			d[i] = longint'(s.a[i]) - longint'(s.b[i]);
			m[i] = (d[i] < 0) ? MW'(-d[i]) : MW'(d[i]);
		end
		sq = 68'(m[0]) * 68'(m[0]) + 68'(m[1]) * 68'(m[1]) + 68'(m[2]) * 68'(m[2]);
		r.degen = (sq == 0);
		for (int i = 0; i < 6; i++) r.grad[i] = '0;
		if (sq == 0) return r;
		root = '0;
		for (int bt = LW - 1; bt >= 0; bt--) begin
			cand = root | (LW'(1) << bt);
			if (68'(cand) * 68'(cand) <= sq) root = cand;
		end
		e = longint'(root) - longint'(s.rest);
		ke = 128'(k) * 128'((e < 0) ? -e : e);
		den = 128'(root) << FRAC_BITS_DEF;
		for (int i = 0; i < 3; i++) begin
			q = (ke * 128'(m[i])) / den;
			if (q > (128'd1 << 62)) q = 128'd1 << 62;
			v = longint'(q[63:0]);
			if ((e < 0) != (d[i] < 0)) v = -v;
			r.grad[i] = clamp32(v);
			r.grad[3 + i] = clamp32(-v);
		end
		return r;
	endfunction

	function automatic spring_t mk_spring(longint ax, longint ay, longint az,
			longint bx, longint by, longint bz, longint rest);
		spring_t s;
		s.a[0] = ax[31:0]; s.a[1] = ay[31:0]; s.a[2] = az[31:0];
		s.b[0] = bx[31:0]; s.b[1] = by[31:0]; s.b[2] = bz[31:0];
		s.rest = rest[30:0];
		return s;
	endfunction

	task automatic add_row(spring_t s, bit typed, logic signed [CW-1:0] ga,
			logic signed [CW-1:0] gb, logic dg);
		stim_row_t r;
		r.s = s;
		r.typed = typed;
		for (int i = 0; i < 3; i++) begin
			r.want.grad[i] = ga;
			r.want.grad[3 + i] = gb;
		end
		r.want.degen = dg;
		rows.push_back(r);
	endtask

	// random spring: mostly nearby pairs with a plausible rest length,
	// plus full-range noise, coincident pairs and corner coordinates
	function automatic spring_t random_spring();
		spring_t s;
		spring_grad_t probe;
		int kind;
		kind = $urandom_range(0, 9);
		for (int i = 0; i < 3; i++) begin
			s.a[i] = $urandom;
			case (kind)
				0: s.b[i] = s.a[i];
				1, 2: s.b[i] = $urandom;
				7: begin
					s.a[i] = $urandom_range(0, 1) ? GMAX : GMIN;
					s.b[i] = $urandom_range(0, 2) == 0 ? s.a[i] : ($urandom_range(0, 1) ? GMAX : GMIN);
				end
				default: s.b[i] = s.a[i] - $signed(32'($urandom_range(0, 1 << 21))) + (1 << 20);
			endcase
		end
		case ($urandom_range(0, 3))
			0: s.rest = 31'($urandom);
			1: s.rest = 31'($urandom_range(0, 1 << 22));
			2: begin
				probe = spring_gradient(s, '0);
				s.rest = probe.degen ? '0 : 31'($urandom_range(0, 1 << 21));
			end
			default: s.rest = $urandom_range(0, 3) == 0 ? 31'h7fffffff : 31'($urandom_range(0, 255));
		endcase
		return s;
	endfunction

	// one transfer in; the expectation is queued at the accepting edge
	task automatic send_spring(spring_t s, bit typed, spring_grad_t want, int idle_pct);
		while ($urandom_range(0, 99) < idle_pct) begin
			@(negedge clk);
			start <= 1'b0;
		end
		@(negedge clk);
		start       <= 1'b1;
		pos_a_x     <= s.a[0];
		pos_a_y     <= s.a[1];
		pos_a_z     <= s.a[2];
		pos_b_x     <= s.b[0];
		pos_b_y     <= s.b[1];
		pos_b_z     <= s.b[2];
		rest_length <= s.rest;
		forever begin
			@(posedge clk);
			if (!busy) break;
		end
		grad_fifo.push_back(typed ? want : spring_gradient(s, stiffness_model));
		sent++;
	endtask

	task automatic drain_pipeline();
		@(negedge clk);
		start <= 1'b0;
		while (grad_fifo.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	task automatic write_stiffness(logic [KW-1:0] k);
		@(negedge clk);
		wr_en   <= 1'b1;
		wr_data <= k;
		@(negedge clk);
		wr_en <= 1'b0;
		stiffness_model = k;
	endtask

	// result checker: every done cycle is one transfer out
	always @(posedge clk) begin
		spring_grad_t exp_g;
		logic signed [CW-1:0] got[6];
		if (done) begin
			got = '{grad_a_x, grad_a_y, grad_a_z, grad_b_x, grad_b_y, grad_b_z};
			if (grad_fifo.size() == 0) begin
				$display("%0t: result with nothing outstanding", $realtime);
				errors++;
			end else begin
				exp_g = grad_fifo.pop_front();
				for (int i = 0; i < 6; i++)
					if (got[i] !== exp_g.grad[i]) begin
						$display("%0t: gradient %0d expected %0d actual %0d", $realtime, i,
							exp_g.grad[i], got[i]);
						errors++;
					end
				if (degenerate !== exp_g.degen) begin
					$display("%0t: degenerate expected %0b actual %0b", $realtime,
						exp_g.degen, degenerate);
					errors++;
				end
			end
		end
	end

	// watchdog: cycles with no transfer in or out, no stiffness write and no reset
	always @(posedge clk) begin
		if ((start && !busy) || done || !arst_n || wr_en) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin
		logic [KW-1:0] phase_k[6];
		spring_grad_t none_g;
		int n;
		sent = 0;
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_data = '0;
		start = 1'b0;
		{pos_a_x, pos_a_y, pos_a_z, pos_b_x, pos_b_y, pos_b_z} = '0;
		rest_length = '0;
		stiffness_model = 31'd65536;  // 1.0 after reset
		for (int i = 0; i < 6; i++) none_g.grad[i] = '0;
		none_g.degen = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed table, run at the reset stiffness
		add_row(mk_spring(0, 0, 0, 0, 0, 0, 0), 1, 0, 0, 1);                    // coincident
		add_row(mk_spring(-2147483648, -2147483648, -2147483648,
			-2147483648, -2147483648, -2147483648, 2147483647), 1, 0, 0, 1);   // coincident at min
		add_row(mk_spring(65536, 0, 0, 0, 0, 0, 65536), 1, 0, 0, 0);            // at rest length
		add_row(mk_spring(0, -65536, 0, 0, 0, 0, 65536), 1, 0, 0, 0);
		add_row(mk_spring(2147483647, 2147483647, 2147483647,
			-2147483648, -2147483648, -2147483648, 0), 1, GMAX, GMIN, 0);      // saturate
		add_row(mk_spring(-2147483648, -2147483648, -2147483648,
			2147483647, 2147483647, 2147483647, 0), 1, GMIN, GMAX, 0);
		add_row(mk_spring(2147483647, 2147483647, 2147483647,
			-2147483648, -2147483648, -2147483648, 2147483647), 0, 0, 0, 0);
		add_row(mk_spring(1, 0, 0, 0, 0, 0, 2147483647), 0, 0, 0, 0);          // compressed
		add_row(mk_spring(0, 0, 131072, 0, 0, 0, 0), 0, 0, 0, 0);
		add_row(mk_spring(0, 0, 0, 0, 0, 1, 0), 0, 0, 0, 0);                    // one lsb apart
		add_row(mk_spring(196608, -262144, 0, 0, 0, 0, 65536), 0, 0, 0, 0);
		add_row(mk_spring(-2147483648, 0, 2147483647, 2147483647, 0, 0, 1000), 0, 0, 0, 0);
		add_row(mk_spring(123456, -654321, 999999, -5, 7, 11, 300000), 0, 0, 0, 0);
		add_row(mk_spring(2147483647, -2147483648, 0, 0, 0, 0, 2147483647), 0, 0, 0, 0);
		foreach (rows[i]) send_spring(rows[i].s, rows[i].typed, rows[i].want, 0);
		drain_pipeline();

		// random phases, each under a new stiffness
		phase_k[0] = '0;
		phase_k[1] = 31'h7fffffff;
		phase_k[2] = 31'($urandom);
		phase_k[3] = 31'd65536;
		phase_k[4] = 31'd1;
		phase_k[5] = 31'($urandom_range(0, 1 << 20));
		n = 0;
		foreach (phase_k[p]) begin
			write_stiffness(phase_k[p]);
			repeat (PER_PHASE) begin
				send_spring(random_spring(), 0, none_g, n < 480 ? 16 : (n < 960 ? 80 : 0));
				n++;
			end
			drain_pipeline();
		end

		if (errors == 0 && grad_fifo.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hdl/sfg_pkg.sv
hdl/sfg_isqrt_pipe.sv
hdl/sfg_div_pipe.sv
hdl/spring_force_gradient.sv
hdl/sfg_checker.sv
verif/tb_spring_force_gradient.sv
